// ===== rtl/text_terminal_cell_engine_core_assert.svh =====
// Assertion macros for the character-cell terminal engine.
// Expects clk and rst_n in the scope of each use.
`ifndef TEXT_TERMINAL_CELL_ENGINE_CORE_ASSERT_SVH
`define TEXT_TERMINAL_CELL_ENGINE_CORE_ASSERT_SVH

// Check a consequence in the same cycle.
`define TTCE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ttce: same-cycle check failed");

// Check a consequence in the following cycle.
`define TTCE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ttce: next-cycle check failed");

`endif

// ===== rtl/ttce_pkg.sv =====
// Shared types and constants of the character-cell terminal engine.
// No dependencies; used by ttce_store and text_terminal_cell_engine_core.
`timescale 1ns / 1ps

package ttce_pkg;

    localparam int MAX_ROW_COUNT_DEF = 64;
    localparam int MAX_COL_COUNT_DEF = 128;
    localparam int GLYPH_COUNT_DEF   = 128;

    localparam int ROW_W  = 6;
    localparam int COL_W  = 7;
    localparam int CFG_AW = 4;

    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;
    localparam logic [7:0] CH_SPACE     = 8'd32;
    localparam logic [7:0] INVERT_MASK  = 8'h0F;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_TOGGLE = 1'b1;
    localparam logic ACT_DRAW    = 1'b0;
    localparam logic ACT_CLEAR   = 1'b1;

    localparam logic [1:0] REG_COLUMNS = 2'd0;
    localparam logic [1:0] REG_ROWS    = 2'd1;
    localparam logic [1:0] REG_FORE    = 2'd2;
    localparam logic [1:0] REG_BACK    = 2'd3;

    localparam logic [7:0] COLUMNS_RST = 8'd80;
    localparam logic [6:0] ROWS_RST    = 7'd25;
    localparam logic [7:0] FORE_RST    = 8'd15;
    localparam logic [7:0] BACK_RST    = 8'd0;

    typedef struct packed {
        logic [7:0] code;
        logic [7:0] fore;
        logic [7:0] back;
    } cell_t;

    localparam cell_t RESET_CELL = '{code: CH_SPACE, fore: FORE_RST, back: BACK_RST};

    typedef struct packed {
        logic       mode;
        logic [7:0] char_code;
    } in_t;

    typedef struct packed {
        logic             action;
        logic [ROW_W-1:0] cell_row;
        logic [COL_W-1:0] cell_col;
        logic [7:0]       glyph;
        logic [7:0]       draw_fore;
        logic [7:0]       draw_back;
        logic [ROW_W-1:0] cursor_row;
        logic [COL_W-1:0] cursor_col;
        logic             last;
    } out_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } store_ctl_t;

endpackage

// ===== rtl/ttce_store.sv =====
// Cell store: one write port, one read port with registered data.
// A read of the entry written in the same cycle returns the new data.
// Depends on ttce_pkg.
`timescale 1ns / 1ps

module ttce_store import ttce_pkg::*; #(
    parameter int DEPTH = MAX_ROW_COUNT_DEF * MAX_COL_COUNT_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          clk,
    input  store_ctl_t    ctl,
    input  logic [AW-1:0] waddr,
    input  cell_t         wdata,
    input  logic [AW-1:0] raddr,
    output cell_t         rdata
);

    cell_t mem [DEPTH];
    cell_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[waddr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            if (ctl.wr_en && (waddr == raddr))
            begin
                rdata_reg <= wdata;
            end
            else
            begin
                rdata_reg <= mem[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/text_terminal_cell_engine_core.sv =====
// Character-cell terminal engine: position, cell store and cursor overlay.
// Depends on ttce_pkg, ttce_store and text_terminal_cell_engine_core_assert.svh.
`timescale 1ns / 1ps
`include "text_terminal_cell_engine_core_assert.svh"

// Usage
//   Input: an item (mode, char_code) transfers at a rising edge with start high
//   and busy low. Mode write acts on a character; mode toggle flips the cursor.
//   Output: each result (a cell draw or a clear-screen command) is on result
//   for one cycle with strobe high; last marks the final result of an item.
//   The receiver cannot stall: strobe is never held off.
//   Config: APB writes to columns, rows, fore_color, back_color at 0, 4, 8, 12,
//   taken only while the block is idle, by rule for the user; the block itself
//   does not enforce it. pready is always high.
//   Sequence: an item steps through the hide, character, show and flush states
//   as needed (each of them for a write with the cursor shown), set by the read
//   and write sequence on the cell store; the next item can transfer in flush.
//   Each result passes a hold and an output register. An item that wraps past
//   the last row sweeps MAX_ROW_COUNT * MAX_COL_COUNT entries (8192 by default)
//   to spaces, one entry per cycle. Reset: the store is swept to spaces with
//   reset colors; busy stays high meanwhile, config writes still land.
module text_terminal_cell_engine_core import ttce_pkg::*; #(
    parameter int MAX_ROW_COUNT = MAX_ROW_COUNT_DEF,
    parameter int MAX_COL_COUNT = MAX_COL_COUNT_DEF,
    parameter int GLYPH_COUNT   = GLYPH_COUNT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              start,
    input  in_t               item,
    output logic              busy,
    output logic              strobe,
    output out_t              result
);

    localparam int ROW_LIM = (MAX_ROW_COUNT < 64) ? MAX_ROW_COUNT : 64;
    localparam int COL_LIM = (MAX_COL_COUNT < 128) ? MAX_COL_COUNT : 128;
    localparam int DEPTH   = MAX_ROW_COUNT * MAX_COL_COUNT;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_HIDE  = 3'd2;
    localparam logic [2:0] ST_CHAR  = 3'd3;
    localparam logic [2:0] ST_SWEEP = 3'd4;
    localparam logic [2:0] ST_SHOW  = 3'd5;
    localparam logic [2:0] ST_FLUSH = 3'd6;

    function automatic logic in_screen(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
                                       input logic [6:0] nrows, input logic [7:0] ncols);
        return ({1'b0, r} < nrows) && ({1'b0, c} < ncols);
    endfunction

    function automatic logic in_store(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
        return (9'(r) < 9'(MAX_ROW_COUNT)) && (9'(c) < 9'(MAX_COL_COUNT));
    endfunction

    function automatic logic [AW-1:0] store_addr(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c);
        return AW'(32'(r) * MAX_COL_COUNT + 32'(c));
    endfunction

    function automatic logic glyph_known(input logic [7:0] code);
        return {1'b0, code} < 9'(GLYPH_COUNT);
    endfunction

    function automatic logic glyph_ok(input logic [7:0] code);
        return (code == CH_SPACE) || glyph_known(code);
    endfunction

    logic [7:0] columns_reg;
    logic [6:0] rows_reg;
    logic [7:0] fore_reg;
    logic [7:0] back_reg;
    logic [7:0] cols_clip;
    logic [7:0] used_cols;
    logic [6:0] rows_clip;
    logic [6:0] used_rows;
    logic       cfg_wr;

    logic [2:0]       state_reg, state_next;
    logic [AW-1:0]    cnt_reg, cnt_next;
    logic [ROW_W-1:0] pos_row_reg, pos_row_next;
    logic [COL_W-1:0] pos_col_reg, pos_col_next;
    logic             cursor_shown_reg, cursor_shown_next;
    logic             saved_valid_reg, saved_valid_next;
    cell_t            saved_cell_reg, saved_cell_next;
    logic             do_write_reg, do_write_next;
    logic             do_char_reg, do_char_next;
    logic             do_clear_reg, do_clear_next;
    logic             do_show_reg, do_show_next;
    logic [ROW_W-1:0] op_row_reg, op_row_next;
    logic [COL_W-1:0] op_col_reg, op_col_next;
    logic [ROW_W-1:0] char_row_reg, char_row_next;
    logic [COL_W-1:0] char_col_reg, char_col_next;
    logic [7:0]       char_code_reg, char_code_next;
    out_t             held_reg, held_next;
    logic             held_valid_reg, held_valid_next;
    logic             strobe_reg, strobe_next;
    out_t             result_reg, result_next;

    logic             acc;
    logic             acc_toggle;
    logic [6:0]       row_inc;
    logic             row_wrap;
    logic [7:0]       col_inc;
    logic [ROW_W-1:0] acc_row;
    logic [COL_W-1:0] acc_col;
    logic [ROW_W-1:0] acc_crow;
    logic [COL_W-1:0] acc_ccol;
    logic [7:0]       acc_code;
    logic             acc_char;
    logic             acc_clear;
    logic             acc_hide;
    logic             acc_show;
    logic [2:0]       acc_first;

    logic             prod_valid;
    out_t             prod;
    out_t             emit;
    cell_t            show_cell;
    cell_t            fill_cell;
    store_ctl_t       store_ctl;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    raddr;
    cell_t            wdata;
    cell_t            rdata;

    // Configuration registers.
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= COLUMNS_RST;
            rows_reg    <= ROWS_RST;
            fore_reg    <= FORE_RST;
            back_reg    <= BACK_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_COLUMNS: columns_reg <= pwdata[7:0];
                REG_ROWS:    rows_reg    <= pwdata[6:0];
                REG_FORE:    fore_reg    <= pwdata[7:0];
                REG_BACK:    back_reg    <= pwdata[7:0];
                default:     columns_reg <= columns_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_COLUMNS: prdata = 32'(columns_reg);
            REG_ROWS:    prdata = 32'(rows_reg);
            REG_FORE:    prdata = 32'(fore_reg);
            REG_BACK:    prdata = 32'(back_reg);
            default:     prdata = '0;
        endcase
    end

    assign cols_clip = (columns_reg == 8'd0) ? 8'd1 : columns_reg;
    assign used_cols = (cols_clip > 8'(COL_LIM)) ? 8'(COL_LIM) : cols_clip;
    assign rows_clip = (rows_reg == 7'd0) ? 7'd1 : rows_reg;
    assign used_rows = (rows_clip > 7'(ROW_LIM)) ? 7'(ROW_LIM) : rows_clip;

    assign fill_cell = '{code: CH_SPACE, fore: fore_reg, back: back_reg};

    // Item decode at transfer.
    assign busy       = !((state_reg == ST_IDLE) || (state_reg == ST_FLUSH));
    assign acc        = start && !busy;
    assign acc_toggle = (item.mode == MODE_TOGGLE);

    always_comb
    begin
        row_inc   = {1'b0, pos_row_reg} + 7'd1;
        row_wrap  = (row_inc >= used_rows);
        col_inc   = {1'b0, pos_col_reg} + 8'd1;
        acc_row   = pos_row_reg;
        acc_col   = pos_col_reg;
        acc_crow  = pos_row_reg;
        acc_ccol  = pos_col_reg;
        acc_code  = item.char_code;
        acc_char  = 1'b0;
        acc_clear = 1'b0;
        if (!acc_toggle)
        begin
            if (item.char_code == CH_BACKSPACE)
            begin
                if (pos_col_reg != '0)
                begin
                    acc_col = pos_col_reg - 7'd1;
                end
                else if (pos_row_reg != '0)
                begin
                    acc_row = pos_row_reg - 6'd1;
                    acc_col = 7'(used_cols - 8'd1);
                end
                acc_crow = acc_row;
                acc_ccol = acc_col;
                acc_code = CH_SPACE;
                acc_char = 1'b1;
            end
            else if (item.char_code == CH_NEWLINE)
            begin
                acc_col   = '0;
                acc_row   = row_wrap ? '0 : row_inc[ROW_W-1:0];
                acc_clear = row_wrap;
            end
            else if (item.char_code == CH_RETURN)
            begin
                acc_col = '0;
            end
            else if (glyph_known(item.char_code))
            begin
                acc_char = 1'b1;
                if (col_inc >= used_cols)
                begin
                    acc_col   = '0;
                    acc_row   = row_wrap ? '0 : row_inc[ROW_W-1:0];
                    acc_clear = row_wrap;
                end
                else
                begin
                    acc_col = col_inc[COL_W-1:0];
                end
            end
        end
        acc_hide = cursor_shown_reg && saved_valid_reg;
        acc_show = acc_toggle ? !cursor_shown_reg : cursor_shown_reg;
        if (acc_hide)
        begin
            acc_first = ST_HIDE;
        end
        else if (!acc_toggle)
        begin
            acc_first = ST_CHAR;
        end
        else if (acc_show)
        begin
            acc_first = ST_SHOW;
        end
        else
        begin
            acc_first = ST_FLUSH;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        pos_row_next      = pos_row_reg;
        pos_col_next      = pos_col_reg;
        cursor_shown_next = cursor_shown_reg;
        saved_valid_next  = saved_valid_reg;
        saved_cell_next   = saved_cell_reg;
        do_write_next     = do_write_reg;
        do_char_next      = do_char_reg;
        do_clear_next     = do_clear_reg;
        do_show_next      = do_show_reg;
        op_row_next       = op_row_reg;
        op_col_next       = op_col_reg;
        char_row_next     = char_row_reg;
        char_col_next     = char_col_reg;
        char_code_next    = char_code_reg;
        store_ctl         = '0;
        waddr             = cnt_reg;
        raddr             = store_addr(pos_row_reg, pos_col_reg);
        wdata             = fill_cell;
        prod_valid        = 1'b0;
        prod              = '0;
        show_cell         = (do_clear_reg || !in_store(pos_row_reg, pos_col_reg)) ?
                            fill_cell : rdata;

        case (state_reg)
            ST_INIT:
            begin
                store_ctl.wr_en = 1'b1;
                wdata           = RESET_CELL;
                if (cnt_reg == AW'(DEPTH - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_HIDE:
            begin
                if (in_screen(op_row_reg, op_col_reg, used_rows, used_cols) &&
                    glyph_ok(saved_cell_reg.code))
                begin
                    prod_valid     = 1'b1;
                    prod.action    = ACT_DRAW;
                    prod.cell_row  = op_row_reg;
                    prod.cell_col  = op_col_reg;
                    prod.glyph     = saved_cell_reg.code;
                    prod.draw_fore = saved_cell_reg.fore;
                    prod.draw_back = saved_cell_reg.back;
                end
                state_next = do_write_reg ? ST_CHAR : ST_FLUSH;
            end
            ST_CHAR:
            begin
                if (do_char_reg)
                begin
                    store_ctl.wr_en = in_store(char_row_reg, char_col_reg);
                    waddr           = store_addr(char_row_reg, char_col_reg);
                    wdata           = '{code: char_code_reg, fore: fore_reg, back: back_reg};
                    if (in_screen(char_row_reg, char_col_reg, used_rows, used_cols))
                    begin
                        prod_valid     = 1'b1;
                        prod.action    = ACT_DRAW;
                        prod.cell_row  = char_row_reg;
                        prod.cell_col  = char_col_reg;
                        prod.glyph     = char_code_reg;
                        prod.draw_fore = fore_reg;
                        prod.draw_back = back_reg;
                    end
                end
                store_ctl.rd_en = do_show_reg && !do_clear_reg &&
                                  in_store(pos_row_reg, pos_col_reg);
                if (do_clear_reg)
                begin
                    state_next = ST_SWEEP;
                end
                else
                begin
                    state_next = do_show_reg ? ST_SHOW : ST_FLUSH;
                end
            end
            ST_SWEEP:
            begin
                store_ctl.wr_en = 1'b1;
                if (cnt_reg == '0)
                begin
                    prod_valid     = 1'b1;
                    prod.action    = ACT_CLEAR;
                    prod.draw_back = back_reg;
                end
                if (cnt_reg == AW'(DEPTH - 1))
                begin
                    cnt_next   = '0;
                    state_next = do_show_reg ? ST_SHOW : ST_FLUSH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SHOW:
            begin
                saved_cell_next = show_cell;
                if (in_screen(pos_row_reg, pos_col_reg, used_rows, used_cols) &&
                    glyph_ok(show_cell.code))
                begin
                    prod_valid     = 1'b1;
                    prod.action    = ACT_DRAW;
                    prod.cell_row  = pos_row_reg;
                    prod.cell_col  = pos_col_reg;
                    prod.glyph     = show_cell.code;
                    prod.draw_fore = show_cell.fore ^ INVERT_MASK;
                    prod.draw_back = show_cell.back ^ INVERT_MASK;
                end
                state_next = ST_FLUSH;
            end
            ST_IDLE, ST_FLUSH:
            begin
                state_next = ST_IDLE;
                if (acc)
                begin
                    state_next        = acc_first;
                    pos_row_next      = acc_row;
                    pos_col_next      = acc_col;
                    cursor_shown_next = acc_toggle ? !cursor_shown_reg : cursor_shown_reg;
                    saved_valid_next  = acc_toggle ? !cursor_shown_reg :
                                        (cursor_shown_reg || saved_valid_reg);
                    do_write_next     = !acc_toggle;
                    do_char_next      = acc_char;
                    do_clear_next     = acc_clear;
                    do_show_next      = acc_show;
                    op_row_next       = pos_row_reg;
                    op_col_next       = pos_col_reg;
                    char_row_next     = acc_crow;
                    char_col_next     = acc_ccol;
                    char_code_next    = acc_code;
                    store_ctl.rd_en   = acc_toggle && acc_show &&
                                        in_store(pos_row_reg, pos_col_reg);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold one result back so that the final one of an item carries last.
    always_comb
    begin
        held_next         = held_reg;
        held_valid_next   = held_valid_reg;
        strobe_next       = 1'b0;
        emit              = held_reg;
        emit.cursor_row   = pos_row_reg;
        emit.cursor_col   = pos_col_reg;
        emit.last         = (state_reg == ST_FLUSH);
        result_next       = emit;
        if (prod_valid)
        begin
            held_next       = prod;
            held_valid_next = 1'b1;
            strobe_next     = held_valid_reg;
        end
        else if (state_reg == ST_FLUSH)
        begin
            held_valid_next = 1'b0;
            strobe_next     = held_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_INIT;
            cnt_reg          <= '0;
            pos_row_reg      <= '0;
            pos_col_reg      <= '0;
            cursor_shown_reg <= 1'b0;
            saved_valid_reg  <= 1'b0;
            saved_cell_reg   <= RESET_CELL;
            do_write_reg     <= 1'b0;
            do_char_reg      <= 1'b0;
            do_clear_reg     <= 1'b0;
            do_show_reg      <= 1'b0;
            held_valid_reg   <= 1'b0;
            strobe_reg       <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            pos_row_reg      <= pos_row_next;
            pos_col_reg      <= pos_col_next;
            cursor_shown_reg <= cursor_shown_next;
            saved_valid_reg  <= saved_valid_next;
            saved_cell_reg   <= saved_cell_next;
            do_write_reg     <= do_write_next;
            do_char_reg      <= do_char_next;
            do_clear_reg     <= do_clear_next;
            do_show_reg      <= do_show_next;
            held_valid_reg   <= held_valid_next;
            strobe_reg       <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_row_reg    <= op_row_next;
        op_col_reg    <= op_col_next;
        char_row_reg  <= char_row_next;
        char_col_reg  <= char_col_next;
        char_code_reg <= char_code_next;
        held_reg      <= held_next;
        result_reg    <= result_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    ttce_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .ctl   (store_ctl),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    `TTCE_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `TTCE_ASSERT_NEXT(a_init_quiet, state_reg == ST_INIT, !strobe_reg)
    `TTCE_ASSERT_NOW(a_idle_drained, state_reg == ST_IDLE, !held_valid_reg)
    `TTCE_ASSERT_NOW(a_cursor_saved, state_reg == ST_IDLE && cursor_shown_reg, saved_valid_reg)

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for text_terminal_cell_engine_core: a scoreboard class
// predicts cell draws and clears per transfer; depends on ttce_pkg and the RTL only.
`timescale 1ns / 1ps

module tb import ttce_pkg::*;;

    localparam int STALL_LIMIT = 40000;
    localparam int STORE_SIZE  = MAX_ROW_COUNT_DEF * MAX_COL_COUNT_DEF;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 21;
    localparam int PHASE_CLEARS = 8;

    localparam int PH_COLS [PHASES] = '{128, 0, 255, 5, 1, 80};
    localparam int PH_ROWS [PHASES] = '{64, 0, 127, 3, 64, 25};
    localparam int PH_FORE [PHASES] = '{255, 0, 8'hA5, 1, 8'h80, 8'h3C};
    localparam int PH_BACK [PHASES] = '{255, 0, 8'h5A, 254, 8'h7F, 8'hC3};
    localparam int PH_IDLE [PHASES] = '{32, 32, 69, 69, 0, 0};

    class terminal_scoreboard;
        logic [7:0] columns;
        logic [6:0] rows;
        logic [7:0] fore_color;
        logic [7:0] back_color;
        int         pos_row;
        int         pos_col;
        bit         cursor_lit;
        bit         saved_valid;
        cell_t      saved;
        cell_t      store [STORE_SIZE];
        out_t       step_out [$];
        out_t       draws_due [$];
        int         errors;

        function new();
            columns     = COLUMNS_RST;
            rows        = ROWS_RST;
            fore_color  = FORE_RST;
            back_color  = BACK_RST;
            pos_row     = 0;
            pos_col     = 0;
            cursor_lit  = 0;
            saved_valid = 0;
            saved       = RESET_CELL;
            errors      = 0;
            foreach (store[i]) store[i] = RESET_CELL;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_COLUMNS: columns = value[7:0];
                REG_ROWS:    rows = value[6:0];
                REG_FORE:    fore_color = value[7:0];
                REG_BACK:    back_color = value[7:0];
                default:     ;
            endcase
        endfunction

        function int cols_used();
            int c;
            c = columns;
            if (c == 0) c = 1;
            if (c > MAX_COL_COUNT_DEF) c = MAX_COL_COUNT_DEF;
            return c;
        endfunction

        function int rows_used();
            int r;
            r = rows;
            if (r == 0) r = 1;
            if (r > MAX_ROW_COUNT_DEF) r = MAX_ROW_COUNT_DEF;
            return r;
        endfunction

        function int pending();
            return draws_due.size();
        endfunction

        function void add_result(logic act, int row, int col, logic [7:0] glyph,
                                 logic [7:0] fg, logic [7:0] bg);
            out_t r;
            if (step_out.size() >= 4) return;
            r           = '0;
            r.action    = act;
            r.cell_row  = row[ROW_W-1:0];
            r.cell_col  = col[COL_W-1:0];
            r.glyph     = glyph;
            r.draw_fore = fg;
            r.draw_back = bg;
            step_out.push_back(r);
        endfunction

        function void paint(int row, int col, logic [7:0] code, logic [7:0] fg,
                            logic [7:0] bg);
            if (row >= rows_used() || col >= cols_used()) return;
            if (code != CH_SPACE && code >= GLYPH_COUNT_DEF) return;
            add_result(ACT_DRAW, row, col, code, fg, bg);
        endfunction

        function cell_t fetch(int row, int col);
            if (row < MAX_ROW_COUNT_DEF && col < MAX_COL_COUNT_DEF)
                return store[row * MAX_COL_COUNT_DEF + col];
            return cell_t'{code: CH_SPACE, fore: fore_color, back: back_color};
        endfunction

        function void put(int row, int col, logic [7:0] code);
            if (row < MAX_ROW_COUNT_DEF && col < MAX_COL_COUNT_DEF)
                store[row * MAX_COL_COUNT_DEF + col] =
                    cell_t'{code: code, fore: fore_color, back: back_color};
        endfunction

        function void show();
            saved       = fetch(pos_row, pos_col);
            saved_valid = 1;
            paint(pos_row, pos_col, saved.code, saved.fore ^ INVERT_MASK,
                  saved.back ^ INVERT_MASK);
            cursor_lit = 1;
        endfunction

        function void hide();
            if (saved_valid)
            begin
                paint(pos_row, pos_col, saved.code, saved.fore, saved.back);
                saved_valid = 0;
            end
            cursor_lit = 0;
        endfunction

        function void advance_row();
            pos_col = 0;
            pos_row++;
            if (pos_row >= rows_used())
            begin
                pos_row = 0;
                add_result(ACT_CLEAR, 0, 0, 8'd0, 8'd0, back_color);
                foreach (store[i])
                    store[i] = cell_t'{code: CH_SPACE, fore: fore_color, back: back_color};
            end
        endfunction

        function void write_code(logic [7:0] ch);
            bit was_on;
            was_on = cursor_lit;
            if (was_on) hide();
            if (ch == CH_BACKSPACE)
            begin
                if (pos_col > 0)
                    pos_col--;
                else if (pos_row > 0)
                begin
                    pos_row--;
                    pos_col = cols_used() - 1;
                end
                paint(pos_row, pos_col, CH_SPACE, fore_color, back_color);
                put(pos_row, pos_col, CH_SPACE);
            end
            else if (ch == CH_NEWLINE)
                advance_row();
            else if (ch == CH_RETURN)
                pos_col = 0;
            else if (ch < GLYPH_COUNT_DEF)
            begin
                paint(pos_row, pos_col, ch, fore_color, back_color);
                put(pos_row, pos_col, ch);
                pos_col++;
                if (pos_col >= cols_used()) advance_row();
            end
            if (was_on) show();
        endfunction

        function bit would_clear(in_t it);
            bit row_ends;
            row_ends = (it.char_code == CH_NEWLINE) ||
                       (it.char_code < GLYPH_COUNT_DEF && it.char_code != CH_BACKSPACE &&
                        it.char_code != CH_RETURN && pos_col + 1 >= cols_used());
            return it.mode == MODE_WRITE && row_ends && pos_row + 1 >= rows_used();
        endfunction

        function void note_item(in_t it);
            step_out.delete();
            if (it.mode == MODE_TOGGLE)
            begin
                if (cursor_lit) hide();
                else show();
            end
            else
                write_code(it.char_code);
            foreach (step_out[k])
            begin
                step_out[k].cursor_row = pos_row[ROW_W-1:0];
                step_out[k].cursor_col = pos_col[COL_W-1:0];
                step_out[k].last       = (k == step_out.size() - 1);
                draws_due.push_back(step_out[k]);
            end
        endfunction

        function void flag(string what);
            errors++;
            if (errors <= 10) $display("mismatch at %0t: %s", $time, what);
        endfunction

        function void check_result(out_t got);
            out_t  want;
            string diff;
            if (draws_due.size() == 0)
            begin
                flag($sformatf("unexpected result %p", got));
                return;
            end
            want = draws_due.pop_front();
            diff = "";
            if (got.action !== want.action)         diff = {diff, " action"};
            if (got.cell_row !== want.cell_row)     diff = {diff, " cell_row"};
            if (got.cell_col !== want.cell_col)     diff = {diff, " cell_col"};
            if (got.glyph !== want.glyph)           diff = {diff, " glyph"};
            if (got.draw_fore !== want.draw_fore)   diff = {diff, " draw_fore"};
            if (got.draw_back !== want.draw_back)   diff = {diff, " draw_back"};
            if (got.cursor_row !== want.cursor_row) diff = {diff, " cursor_row"};
            if (got.cursor_col !== want.cursor_col) diff = {diff, " cursor_col"};
            if (got.last !== want.last)             diff = {diff, " last"};
            if (diff != "")
                flag($sformatf("field%s: expected %p, got %p", diff, want, got));
        endfunction
    endclass

    logic              clk     = 1'b0;
    logic              rst_n   = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [CFG_AW-1:0] paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              start   = 1'b0;
    in_t               item    = '0;
    logic              busy;
    logic              strobe;
    out_t              result;

    terminal_scoreboard sb;
    int idle_cycles = 0;

    text_terminal_cell_engine_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .start   (start),
        .item    (item),
        .busy    (busy),
        .strobe  (strobe),
        .result  (result)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(negedge clk)
    begin
        if (rst_n && strobe) sb.check_result(result);
    end

    always @(posedge clk)
    begin
        if (!rst_n || strobe || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_item(in_t it);
        start <= 1'b1;
        item  <= it;
        do @(posedge clk); while (busy);
        sb.note_item(it);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    // hold off input until every expected result has arrived
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic settle();
        drain();
        do @(posedge clk); while (busy);
        repeat (8) @(posedge clk);
    endtask

    function automatic in_t pick_item();
        in_t it;
        int  r;
        r            = $urandom_range(99);
        it.mode      = MODE_WRITE;
        it.char_code = 8'($urandom_range(255));
        if (r < 15)
            it.mode = MODE_TOGGLE;
        else if (r < 60)
            it.char_code = 8'($urandom_range(GLYPH_COUNT_DEF - 1));
        else if (r < 70)
            it.char_code = CH_BACKSPACE;
        else if (r < 78)
            it.char_code = CH_NEWLINE;
        else if (r < 85)
            it.char_code = CH_RETURN;
        return it;
    endfunction

    initial
    begin
        in_t it;
        int  clears_left;
        int  idle_pct;
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(in_t'{MODE_WRITE, 8'h48});
        send_item(in_t'{MODE_WRITE, 8'h00});
        send_item(in_t'{MODE_WRITE, 8'h7F});
        send_item(in_t'{MODE_WRITE, 8'h80});
        send_item(in_t'{MODE_TOGGLE, 8'hFF});
        send_item(in_t'{MODE_WRITE, 8'hFF});
        send_item(in_t'{MODE_WRITE, 8'h61});
        send_item(in_t'{MODE_WRITE, CH_BACKSPACE});
        send_item(in_t'{MODE_WRITE, CH_RETURN});
        send_item(in_t'{MODE_WRITE, CH_BACKSPACE});
        send_item(in_t'{MODE_WRITE, CH_NEWLINE});
        send_item(in_t'{MODE_WRITE, CH_BACKSPACE});
        send_item(in_t'{MODE_WRITE, 8'h7A});
        send_item(in_t'{MODE_TOGGLE, 8'h00});
        send_item(in_t'{MODE_TOGGLE, CH_NEWLINE});
        send_item(in_t'{MODE_TOGGLE, 8'h55});
        send_item(in_t'{MODE_WRITE, CH_NEWLINE});
        send_item(in_t'{MODE_WRITE, CH_SPACE});
        send_item(in_t'{MODE_WRITE, CH_RETURN});
        send_item(in_t'{MODE_WRITE, CH_BACKSPACE});
        send_item(in_t'{MODE_WRITE, 8'hC8});
        send_item(in_t'{MODE_WRITE, 8'h7E});

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            write_reg(REG_COLUMNS, PH_COLS[p]);
            write_reg(REG_ROWS, PH_ROWS[p]);
            write_reg(REG_FORE, PH_FORE[p]);
            write_reg(REG_BACK, PH_BACK[p]);
            idle_pct    = PH_IDLE[p];
            clears_left = PHASE_CLEARS;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                while ($urandom_range(99) < idle_pct)
                begin
                    start <= 1'b0;
                    @(posedge clk);
                end
                if ($urandom_range(99) < 2) drain();
                it = pick_item();
                // cap the number of full-store sweeps per phase
                if (sb.would_clear(it))
                begin
                    if (clears_left == 0)
                        it = in_t'{MODE_WRITE, CH_RETURN};
                    else
                        clears_left--;
                end
                send_item(it);
            end
        end

        settle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
